FILE: rtl/core/lcdns_pkg.sv
// Package for the character LCD nibble sequencer.
// Holds the microcode word, the program ROM and the wait table.
// No dependencies.
`default_nettype none

package lcdns_pkg;

    // Request kinds on s_tuser
    localparam logic [3:0] REQ_INIT    = 4'd0;
    localparam logic [3:0] REQ_RELEASE = 4'd1;
    localparam logic [3:0] REQ_CLEAR   = 4'd2;
    localparam logic [3:0] REQ_HOME    = 4'd3;
    localparam logic [3:0] REQ_CHAR    = 4'd4;
    localparam logic [3:0] REQ_MOVE    = 4'd5;
    localparam logic [3:0] REQ_DISPLAY = 4'd6;
    localparam logic [3:0] REQ_CURSOR  = 4'd7;
    localparam logic [3:0] REQ_BLINK   = 4'd8;

    // Program addresses
    localparam logic [3:0] PC_INIT  = 4'd0;
    localparam logic [3:0] PC_CLEAR = 4'd9;
    localparam logic [3:0] PC_HOME  = 4'd10;
    localparam logic [3:0] PC_CHAR  = 4'd11;
    localparam logic [3:0] PC_MOVE  = 4'd12;
    localparam logic [3:0] PC_DISP  = 4'd13;
    localparam logic [3:0] PC_ERROR = 4'd14;

    // Byte source of a step
    localparam logic [1:0] SRC_CONST = 2'd0;
    localparam logic [1:0] SRC_OPND  = 2'd1;
    localparam logic [1:0] SRC_DISP  = 2'd2;

    // Wait codes for the final byte of a step
    localparam logic [2:0] W_4500 = 3'd0;
    localparam logic [2:0] W_150  = 3'd1;
    localparam logic [2:0] W_250  = 3'd2;
    localparam logic [2:0] W_110  = 3'd3;
    localparam logic [2:0] W_5110 = 3'd4;
    localparam logic [2:0] W_5010 = 3'd5;
    localparam logic [2:0] W_1610 = 3'd6;
    localparam logic [2:0] W_60   = 3'd7;

    localparam logic [12:0] WAIT_EN_HIGH = 13'd2;
    localparam logic [12:0] WAIT_NIBBLE  = 13'd10;

    // Move command parts
    localparam logic [7:0] MOVE_CMD = 8'h80;
    localparam logic [7:0] MAX_COL  = 8'h27;
    localparam logic [7:0] ROW1_OFS = 8'h40;

    typedef struct packed {
        logic [1:0] src;       // byte source
        logic [7:0] cbyte;     // constant byte
        logic       rs;        // register select (data)
        logic       nib_only;  // send the high nibble only
        logic [2:0] wcode;     // wait code of the final byte
        logic       last;      // final step of the program
        logic       err;       // error result step
    } ctrl_word_t;

    function automatic ctrl_word_t cw(input logic [1:0] src, input logic [7:0] cbyte,
                                      input logic rs, input logic nib,
                                      input logic [2:0] wcode, input logic last);
        ctrl_word_t w;
        w.src      = src;
        w.cbyte    = cbyte;
        w.rs       = rs;
        w.nib_only = nib;
        w.wcode    = wcode;
        w.last     = last;
        w.err      = 1'b0;
        return w;
    endfunction

    // Program ROM: wake-up nibbles, setup commands, request entries and an error step
    function automatic ctrl_word_t prog_rom(input logic [3:0] pc);
        ctrl_word_t w;
        unique case (pc)
            4'd0:    w = cw(SRC_CONST, 8'h30, 1'b0, 1'b1, W_4500, 1'b0);
            4'd1:    w = cw(SRC_CONST, 8'h30, 1'b0, 1'b1, W_150,  1'b0);
            4'd2:    w = cw(SRC_CONST, 8'h30, 1'b0, 1'b1, W_150,  1'b0);
            4'd3:    w = cw(SRC_CONST, 8'h20, 1'b0, 1'b1, W_250,  1'b0);
            4'd4:    w = cw(SRC_CONST, 8'h28, 1'b0, 1'b0, W_110,  1'b0);
            4'd5:    w = cw(SRC_CONST, 8'h14, 1'b0, 1'b0, W_110,  1'b0);
            4'd6:    w = cw(SRC_DISP,  8'h00, 1'b0, 1'b0, W_110,  1'b0);
            4'd7:    w = cw(SRC_CONST, 8'h06, 1'b0, 1'b0, W_110,  1'b0);
            4'd8:    w = cw(SRC_CONST, 8'h01, 1'b0, 1'b0, W_5110, 1'b1);
            4'd9:    w = cw(SRC_CONST, 8'h01, 1'b0, 1'b0, W_5010, 1'b1);
            4'd10:   w = cw(SRC_CONST, 8'h02, 1'b0, 1'b0, W_1610, 1'b1);
            4'd11:   w = cw(SRC_OPND,  8'h00, 1'b1, 1'b0, W_60,   1'b1);
            4'd12:   w = cw(SRC_OPND,  8'h00, 1'b0, 1'b0, W_60,   1'b1);
            4'd13:   w = cw(SRC_DISP,  8'h00, 1'b0, 1'b0, W_60,   1'b1);
            default: begin
                // error result step
                w     = cw(SRC_CONST, 8'h00, 1'b0, 1'b1, W_60, 1'b1);
                w.err = 1'b1;
            end
        endcase
        return w;
    endfunction

    function automatic logic [12:0] wait_of(input logic [2:0] code);
        logic [12:0] v;
        unique case (code)
            W_4500:  v = 13'd4500;
            W_150:   v = 13'd150;
            W_250:   v = 13'd250;
            W_110:   v = 13'd110;
            W_5110:  v = 13'd5110;
            W_5010:  v = 13'd5010;
            W_1610:  v = 13'd1610;
            default: v = 13'd60;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer, top level.
// Microcoded: program ROM and wait table from lcdns_pkg.
//
//  channel | dir | accept               | carries
//  s_      | in  | s_tvalid & s_tready  | one LCD request
//  m_      | out | m_tvalid & m_tready  | one expander byte with its wait
//
// One expander byte per cycle while the output is taken. A request holds the
// input busy until its last byte is emitted: init 28 bytes, clear/home/char/move/
// display/cursor/blink 4 each, an error result 1, release none.
// The step counter and a 2-bit byte phase set the byte count; a new request is
// taken the cycle after the last byte leaves the sequencer.
// aresetn (synchronous) clears the flags, the sequencer and the output valid.
// A stalled output holds the sequencer; the input stays ready whenever idle.
`default_nettype none

module char_lcd_nibble_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // char_code[7:0], row_index[15:8],
                                        // col_index[23:16], enable_flag[24], zero fill
    input  wire logic [3:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // port_byte[7:0], wait_us[20:8], zero fill
    output logic             m_tlast,   // last_of_run
    output logic             m_tuser    // not_attached_error
);

    // State flags
    logic attached_reg, attached_next;
    logic bl_reg, bl_next;
    logic disp_reg, disp_next;
    logic curs_reg, curs_next;
    logic blink_reg, blink_next;

    // Sequencer
    logic       run_reg, run_next;
    logic [3:0] pc_reg, pc_next;
    logic [1:0] ph_reg, ph_next;
    logic [7:0] opnd_reg, opnd_next;

    // Output register
    logic        mv_reg, mv_next;
    logic [7:0]  mbyte_reg, mbyte_next;
    logic [12:0] mwait_reg, mwait_next;
    logic        mlast_reg, mlast_next;
    logic        merr_reg, merr_next;

    lcdns_pkg::ctrl_word_t cw;
    logic       s_acc;
    logic       emit;
    logic       step_end;
    logic [7:0] src_byte;
    logic [7:0] disp_byte;
    logic [3:0] nib;
    logic [7:0] row_c;
    logic [7:0] col_c;
    logic [3:0] req;

    assign req       = s_tuser;
    assign s_tready  = !run_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign emit      = run_reg && (!mv_reg || m_tready);
    assign cw        = lcdns_pkg::prog_rom(pc_reg);
    assign disp_byte = {4'b0000, 1'b1, disp_reg, curs_reg, blink_reg};

    // Move target clamp
    assign row_c = (s_tdata[15:8] != 8'd0) ? lcdns_pkg::ROW1_OFS : 8'd0;
    assign col_c = (s_tdata[23:16] > lcdns_pkg::MAX_COL) ? lcdns_pkg::MAX_COL
                                                          : s_tdata[23:16];

    // Datapath: byte source and nibble select
    always_comb begin
        unique case (cw.src)
            lcdns_pkg::SRC_OPND: src_byte = opnd_reg;
            lcdns_pkg::SRC_DISP: src_byte = disp_byte;
            default:             src_byte = cw.cbyte;
        endcase
        nib      = ph_reg[1] ? src_byte[3:0] : src_byte[7:4];
        step_end = cw.err || (ph_reg[0] && (cw.nib_only || ph_reg[1]));
    end

    // Request decode and flag updates
    always_comb begin
        attached_next = attached_reg;
        bl_next       = bl_reg;
        disp_next     = disp_reg;
        curs_next     = curs_reg;
        blink_next    = blink_reg;
        run_next      = run_reg;
        pc_next       = pc_reg;
        ph_next       = ph_reg;
        opnd_next     = opnd_reg;

        if (emit) begin
            if (step_end) begin
                ph_next = 2'd0;
                if (cw.last) begin
                    run_next = 1'b0;
                end else begin
                    pc_next = pc_reg + 4'd1;
                end
            end else begin
                ph_next = ph_reg + 2'd1;
            end
        end

        if (s_acc) begin
            ph_next = 2'd0;
            if (req == lcdns_pkg::REQ_CHAR) begin
                opnd_next = s_tdata[7:0];
            end else begin
                opnd_next = lcdns_pkg::MOVE_CMD | (row_c + col_c);
            end
            priority if (req > lcdns_pkg::REQ_BLINK) begin
                // unknown request: dropped
            end else if (req == lcdns_pkg::REQ_RELEASE) begin
                attached_next = 1'b0;
                bl_next       = 1'b0;
            end else if (req == lcdns_pkg::REQ_INIT) begin
                attached_next = 1'b1;
                bl_next       = 1'b1;
                disp_next     = 1'b1;
                curs_next     = 1'b1;
                blink_next    = 1'b1;
                run_next      = 1'b1;
                pc_next       = lcdns_pkg::PC_INIT;
            end else if (!attached_reg) begin
                run_next = 1'b1;
                pc_next  = lcdns_pkg::PC_ERROR;
            end else begin
                run_next = 1'b1;
                unique case (req)
                    lcdns_pkg::REQ_CLEAR: pc_next = lcdns_pkg::PC_CLEAR;
                    lcdns_pkg::REQ_HOME:  pc_next = lcdns_pkg::PC_HOME;
                    lcdns_pkg::REQ_CHAR:  pc_next = lcdns_pkg::PC_CHAR;
                    lcdns_pkg::REQ_MOVE:  pc_next = lcdns_pkg::PC_MOVE;
                    lcdns_pkg::REQ_DISPLAY: begin
                        pc_next   = lcdns_pkg::PC_DISP;
                        disp_next = s_tdata[24];
                    end
                    lcdns_pkg::REQ_CURSOR: begin
                        pc_next   = lcdns_pkg::PC_DISP;
                        curs_next = s_tdata[24];
                    end
                    default: begin
                        pc_next    = lcdns_pkg::PC_DISP;
                        blink_next = s_tdata[24];
                    end
                endcase
            end
        end
    end

    // Output register load
    always_comb begin
        mv_next    = mv_reg && !m_tready;
        mbyte_next = mbyte_reg;
        mwait_next = mwait_reg;
        mlast_next = mlast_reg;
        merr_next  = merr_reg;
        if (emit) begin
            mv_next    = 1'b1;
            mlast_next = step_end && cw.last;
            merr_next  = cw.err;
            if (cw.err) begin
                mbyte_next = 8'd0;
                mwait_next = 13'd0;
            end else begin
                mbyte_next = {nib, bl_reg, !ph_reg[0], 1'b0, cw.rs};
                if (!ph_reg[0]) begin
                    mwait_next = lcdns_pkg::WAIT_EN_HIGH;
                end else if (step_end) begin
                    mwait_next = lcdns_pkg::wait_of(cw.wcode);
                end else begin
                    mwait_next = lcdns_pkg::WAIT_NIBBLE;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attached_reg <= 1'b0;
            bl_reg       <= 1'b0;
            disp_reg     <= 1'b0;
            curs_reg     <= 1'b0;
            blink_reg    <= 1'b0;
            run_reg      <= 1'b0;
            pc_reg       <= 4'd0;
            ph_reg       <= 2'd0;
            mv_reg       <= 1'b0;
        end else begin
            attached_reg <= attached_next;
            bl_reg       <= bl_next;
            disp_reg     <= disp_next;
            curs_reg     <= curs_next;
            blink_reg    <= blink_next;
            run_reg      <= run_next;
            pc_reg       <= pc_next;
            ph_reg       <= ph_next;
            mv_reg       <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        opnd_reg  <= opnd_next;
        mbyte_reg <= mbyte_next;
        mwait_reg <= mwait_next;
        mlast_reg <= mlast_next;
        merr_reg  <= merr_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'b000, mwait_reg, mbyte_reg};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = merr_reg;

    // Error result is a lone, empty byte
    a_err_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[20:0] == 21'd0 && m_tlast)
        else $error("error result carries data");

    // Enable-high bytes always wait the short strobe time, and only they do
    a_strobe_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[2] == (m_tdata[20:8] == lcdns_pkg::WAIT_EN_HIGH))
        else $error("enable strobe and wait disagree");

    // The program stops right after its final byte
    a_run_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && step_end && cw.last |=> !run_reg && m_tlast)
        else $error("sequencer ran past final step");

    // The enable-low byte that ends a pulse carries the step's register select
    a_rs_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && ph_reg[0] && !cw.err |=> m_tdata[0] == $past(cw.rs))
        else $error("register select changed within a nibble");

endmodule

`default_nettype wire

FILE: tb/tb_char_lcd_nibble_sequencer.sv
// Self-checking testbench for char_lcd_nibble_sequencer: a queued request driver,
// an expander byte monitor and an in-line predictor of the LCD byte runs.
// Depends on lcdns_pkg and the char_lcd_nibble_sequencer RTL.
`default_nettype none

module tb_char_lcd_nibble_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_REQS  = 138;

    // Unused request codes are ignored by the block
    localparam logic [3:0] REQ_UNUSED_MIN = lcdns_pkg::REQ_BLINK + 4'd1;
    localparam logic [3:0] REQ_UNUSED_MAX = 4'hF;

    // Expander bit positions
    localparam logic [7:0] BIT_RS = 8'h01;
    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;

    // Extra waits on the last byte of a command
    localparam logic [12:0] XW_INIT  = 13'd100;
    localparam logic [12:0] XW_CLEAR = 13'd5000;
    localparam logic [12:0] XW_HOME  = 13'd1600;
    localparam logic [12:0] XW_CMD   = 13'd50;
    localparam logic [12:0] WAKE_LONG  = 13'd4500;
    localparam logic [12:0] WAKE_SHORT = 13'd150;

    // LCD command bytes
    localparam logic [7:0] CMD_WAKE8    = 8'h30;
    localparam logic [7:0] CMD_WAKE4    = 8'h20;
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_SHIFT    = 8'h14;
    localparam logic [7:0] CMD_ENTRY    = 8'h06;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;
    localparam logic [7:0] CMD_HOME     = 8'h02;
    localparam logic [7:0] CMD_DISPCTL  = 8'h08;

    typedef struct {
        logic [3:0] req_type;
        logic [7:0] char_code;
        logic [7:0] row_index;
        logic [7:0] col_index;
        logic       enable_flag;
        int         phase;
    } lcd_req_t;

    typedef struct {
        logic [7:0]  port_byte;
        logic [12:0] wait_us;
        logic        last_of_run;
        logic        not_attached_error;
    } lcd_byte_t;

    // Idle percentages per phase: sender, receiver
    int send_idle_pct [3] = '{11, 59, 0};
    int recv_idle_pct [3] = '{59, 11, 0};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = lcdns_pkg::REQ_INIT;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    lcd_req_t  pending_reqs[$];
    lcd_byte_t expected_bytes[$];
    lcd_req_t  cur_req;
    lcd_byte_t got_exp;
    int        idle_phase   = 0;
    int        reqs_total   = 0;
    int        reqs_taken   = 0;
    int        fail_count   = 0;
    int        cycle_count  = 0;

    // Predictor copy of the LCD flags
    logic lcd_attached  = 1'b0;
    logic lcd_backlight = 1'b0;
    logic lcd_display   = 1'b0;
    logic lcd_cursor    = 1'b0;
    logic lcd_blink     = 1'b0;

    // Stimulus generator's view of the attach state
    logic gen_attached = 1'b0;

    char_lcd_nibble_sequencer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [7:0] display_ctrl_byte();
        return CMD_DISPCTL | {5'b0, lcd_display, lcd_cursor, lcd_blink};
    endfunction

    // One nibble (bits 7-4, RS in bit 0): enable-high byte then enable-low byte
    task automatic emit_nibble(input logic [7:0] v, input logic [12:0] delay);
        lcd_byte_t  b;
        logic [7:0] bl;
        bl = lcd_backlight ? BIT_BL : 8'h00;
        b.last_of_run        = 1'b0;
        b.not_attached_error = 1'b0;
        b.port_byte = v | BIT_EN | bl;
        b.wait_us   = lcdns_pkg::WAIT_EN_HIGH;
        expected_bytes.push_back(b);
        b.port_byte = (v & ~BIT_EN) | bl;
        b.wait_us   = delay;
        expected_bytes.push_back(b);
    endtask

    // Full byte, high nibble first; extra wait lands on the final byte
    task automatic emit_cmd(input logic [7:0] cmd, input logic data, input logic [12:0] extra);
        logic [7:0] rs;
        rs = data ? BIT_RS : 8'h00;
        emit_nibble((cmd & 8'hF0) | rs, lcdns_pkg::WAIT_NIBBLE);
        emit_nibble({cmd[3:0], 4'h0} | rs, lcdns_pkg::WAIT_NIBBLE + extra);
    endtask

    // Expected expander bytes for one accepted request
    task automatic predict_lcd_bytes(input lcd_req_t r);
        int         n0;
        lcd_byte_t  e;
        logic [7:0] row_c;
        logic [7:0] col_c;
        n0 = expected_bytes.size();
        if (r.req_type > lcdns_pkg::REQ_BLINK) begin
            // ignored request
        end else if (r.req_type == lcdns_pkg::REQ_RELEASE) begin
            lcd_attached  = 1'b0;
            lcd_backlight = 1'b0;
        end else if (r.req_type != lcdns_pkg::REQ_INIT && !lcd_attached) begin
            e.port_byte          = 8'h00;
            e.wait_us            = 13'd0;
            e.last_of_run        = 1'b1;
            e.not_attached_error = 1'b1;
            expected_bytes.push_back(e);
        end else begin
            case (r.req_type)
                lcdns_pkg::REQ_INIT: begin
                    lcd_attached  = 1'b1;
                    lcd_backlight = 1'b1;
                    lcd_display   = 1'b1;
                    lcd_cursor    = 1'b1;
                    lcd_blink     = 1'b1;
                    emit_nibble(CMD_WAKE8, WAKE_LONG);
                    emit_nibble(CMD_WAKE8, WAKE_SHORT);
                    emit_nibble(CMD_WAKE8, WAKE_SHORT);
                    emit_nibble(CMD_WAKE4, WAKE_SHORT + XW_INIT);
                    emit_cmd(CMD_FUNC_SET, 1'b0, XW_INIT);
                    emit_cmd(CMD_SHIFT, 1'b0, XW_INIT);
                    emit_cmd(display_ctrl_byte(), 1'b0, XW_INIT);
                    emit_cmd(CMD_ENTRY, 1'b0, XW_INIT);
                    emit_cmd(CMD_CLEAR, 1'b0, XW_CLEAR + XW_INIT);
                end
                lcdns_pkg::REQ_CLEAR: emit_cmd(CMD_CLEAR, 1'b0, XW_CLEAR);
                lcdns_pkg::REQ_HOME:  emit_cmd(CMD_HOME, 1'b0, XW_HOME);
                lcdns_pkg::REQ_CHAR:  emit_cmd(r.char_code, 1'b1, XW_CMD);
                lcdns_pkg::REQ_MOVE: begin
                    // row clamps to 1, column to the last DDRAM column
                    row_c = (r.row_index > 8'd1) ? 8'd1 : r.row_index;
                    col_c = (r.col_index > lcdns_pkg::MAX_COL) ? lcdns_pkg::MAX_COL
                                                               : r.col_index;
                    emit_cmd(lcdns_pkg::MOVE_CMD |
                             (((row_c[0] ? lcdns_pkg::ROW1_OFS : 8'h00) + col_c) & 8'h7F),
                             1'b0, XW_CMD);
                end
                lcdns_pkg::REQ_DISPLAY: begin
                    lcd_display = r.enable_flag;
                    emit_cmd(display_ctrl_byte(), 1'b0, XW_CMD);
                end
                lcdns_pkg::REQ_CURSOR: begin
                    lcd_cursor = r.enable_flag;
                    emit_cmd(display_ctrl_byte(), 1'b0, XW_CMD);
                end
                default: begin
                    lcd_blink = r.enable_flag;
                    emit_cmd(display_ctrl_byte(), 1'b0, XW_CMD);
                end
            endcase
            if (expected_bytes.size() > n0)
                expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
        end
    endtask

    task automatic add_req(input logic [3:0] t, input logic [7:0] ch, input logic [7:0] row,
                           input logic [7:0] col, input logic en, input int ph);
        lcd_req_t r;
        r.req_type    = t;
        r.char_code   = ch;
        r.row_index   = row;
        r.col_index   = col;
        r.enable_flag = en;
        r.phase       = ph;
        pending_reqs.push_back(r);
        reqs_total++;
    endtask

    // Random request, mostly well-formed while attached
    task automatic add_random_req(input int ph);
        int         pick;
        logic [3:0] t;
        logic [7:0] row;
        logic [7:0] col;
        pick = $urandom_range(99);
        if (!gen_attached && pick < 40)
            t = lcdns_pkg::REQ_INIT;
        else if (pick < 4)
            t = lcdns_pkg::REQ_INIT;
        else if (pick < 8)
            t = lcdns_pkg::REQ_RELEASE;
        else if (pick < 11)
            t = 4'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
        else
            t = 4'($urandom_range(lcdns_pkg::REQ_CLEAR, lcdns_pkg::REQ_BLINK));
        // move targets often sit around the clamp limits
        if ($urandom_range(1)) begin
            row = 8'($urandom_range(2));
            col = 8'($urandom_range(lcdns_pkg::MAX_COL - 3, lcdns_pkg::MAX_COL + 3));
        end else begin
            row = 8'($urandom);
            col = 8'($urandom);
        end
        if (t == lcdns_pkg::REQ_INIT)
            gen_attached = 1'b1;
        else if (t == lcdns_pkg::REQ_RELEASE)
            gen_attached = 1'b0;
        add_req(t, 8'($urandom), row, col, 1'($urandom), ph);
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_lcd_bytes(cur_req);
                reqs_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct[pending_reqs[0].phase]) begin
                    cur_req = pending_reqs.pop_front();
                    idle_phase <= cur_req.phase;
                    s_tvalid   <= 1'b1;
                    s_tuser    <= cur_req.req_type;
                    s_tdata    <= {7'b0, cur_req.enable_flag, cur_req.col_index,
                                   cur_req.row_index, cur_req.char_code};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Expander byte monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte: port_byte %h wait_us %0d", m_tdata[7:0],
                           m_tdata[20:8]);
                    fail_count++;
                end else begin
                    got_exp = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== got_exp.port_byte) begin
                        $error("port_byte: expected %h, got %h", got_exp.port_byte,
                               m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[20:8] !== got_exp.wait_us) begin
                        $error("wait_us: expected %0d, got %0d", got_exp.wait_us,
                               m_tdata[20:8]);
                        fail_count++;
                    end
                    if (m_tlast !== got_exp.last_of_run) begin
                        $error("last_of_run: expected %b, got %b", got_exp.last_of_run,
                               m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== got_exp.not_attached_error) begin
                        $error("not_attached_error: expected %b, got %b",
                               got_exp.not_attached_error, m_tuser);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // while released each request gives one error byte, but release and unused codes none
        add_req(lcdns_pkg::REQ_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CHAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
        add_req(lcdns_pkg::REQ_MOVE, 8'h00, 8'h01, 8'h05, 1'b0, 0);
        add_req(lcdns_pkg::REQ_DISPLAY, 8'h00, 8'h00, 8'h00, 1'b1, 0);
        add_req(lcdns_pkg::REQ_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(REQ_UNUSED_MAX, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
        add_req(lcdns_pkg::REQ_INIT, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_HOME, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CHAR, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CHAR, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
        // move: corners and beyond the clamps
        add_req(lcdns_pkg::REQ_MOVE, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_MOVE, 8'h00, 8'h01, lcdns_pkg::MAX_COL, 1'b0, 0);
        add_req(lcdns_pkg::REQ_MOVE, 8'h00, 8'h02, lcdns_pkg::MAX_COL + 8'd1, 1'b0, 0);
        add_req(lcdns_pkg::REQ_MOVE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 0);
        add_req(lcdns_pkg::REQ_DISPLAY, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CURSOR, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_BLINK, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_DISPLAY, 8'h00, 8'h00, 8'h00, 1'b1, 0);
        // release drops the backlight; re-init brings it back
        add_req(lcdns_pkg::REQ_RELEASE, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_CHAR, 8'h41, 8'h00, 8'h00, 1'b0, 0);
        add_req(lcdns_pkg::REQ_INIT, 8'h00, 8'h00, 8'h00, 1'b0, 0);
        gen_attached = 1'b1;
        for (int i = 0; i < RANDOM_REQS; i++)
            add_random_req(i * 3 / RANDOM_REQS);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (reqs_taken < reqs_total || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: char_lcd_nibble_sequencer.f
rtl/core/lcdns_pkg.sv
rtl/core/char_lcd_nibble_sequencer.sv
tb/tb_char_lcd_nibble_sequencer.sv
